### sv/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the HSV to RGB converter.
package hsvrgb_pkg;

   localparam int HUE_W        = 17;
   localparam int CHAN_W       = 8;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // Hue is scaled to thousandths of a sixth of a turn
   localparam int HUE_STEPS    = 6000;
   localparam int SECTOR_SPAN  = 1000;
   localparam int SECTOR_COUNT = 6;
   localparam int K_W          = 10;

   // floor(x / 255) for 16-bit x: multiply by reciprocal, keep bits above P_SHIFT
   localparam int PROD_W       = 16;
   localparam int P_SHIFT      = 24;
   localparam int P_RECIP_W    = 17;
   localparam logic [P_RECIP_W-1:0] P_RECIP =
      P_RECIP_W'(((64'd1 << P_SHIFT) + 64'd254) / 64'd255);

   // floor(x / 255000) for 26-bit x
   localparam int NUM_W         = 18;
   localparam logic [NUM_W-1:0] SCALE_FULL = 18'd255000;
   localparam int SCALE_PROD_W  = 26;
   localparam int SCALE_SHIFT   = 44;
   localparam int SCALE_RECIP_W = 27;
   localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP =
      SCALE_RECIP_W'(((64'd1 << SCALE_SHIFT) + 64'd254999) / 64'd255000);

   // Cycles from an accepted transaction to its result strobe
   localparam int LATENCY = 7;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

endpackage

### sv/hsvrgb_scale.sv
`timescale 1ns / 1ps
// Two-stage scaler: floor(value * factor / 255000).
module hsvrgb_scale
   import hsvrgb_pkg::*;
(
   input  logic                  clock,
   input  logic [CHAN_W-1:0]     value,
   input  logic [NUM_W-1:0]      factor,
   output logic [CHAN_W-1:0]     scaled
);

   localparam int RP_W = SCALE_PROD_W + SCALE_RECIP_W;

   logic [SCALE_PROD_W-1:0] prod_ff;
   logic [SCALE_PROD_W-1:0] prod_in;
   logic [CHAN_W-1:0]       res_ff;
   logic [CHAN_W-1:0]       res_in;
   logic [RP_W-1:0]         recip_prod;

   assign prod_in    = SCALE_PROD_W'(value) * SCALE_PROD_W'(factor);
   // product never exceeds 255 * 255000, so the reciprocal is exact here
   assign recip_prod = RP_W'(prod_ff) * RP_W'(SCALE_RECIP);
   assign res_in     = recip_prod[SCALE_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign scaled = res_ff;

endmodule

### sv/hsv_to_rgb_fixed_hue.sv
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter.
//
// Converts one hue, saturation and brightness to 8-bit red, green and blue per clock. A
// transaction is taken on any edge with start high; busy is always low, so a new colour
// may follow in every cycle. The result appears on rsp_* with rsp_valid high for one
// cycle, in the order of acceptance. The latency is set by the chain of seven register
// stages: hue scaling, division by 1000 through a reciprocal multiply, the remainder
// within the sector, the sector reduction modulo 6, the two-stage brightness scaler and
// the output select. Hue wraps every full turn; the receiver cannot stall.
module hsv_to_rgb_fixed_hue
   import hsvrgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [HUE_W-1:0]   req_hue,
   input  logic [CHAN_W-1:0]  req_saturation,
   input  logic [CHAN_W-1:0]  req_brightness,
   output logic               rsp_valid,
   output logic [CHAN_W-1:0]  rsp_red,
   output logic [CHAN_W-1:0]  rsp_green,
   output logic [CHAN_W-1:0]  rsp_blue
);

   localparam int SPAN_L = $clog2(SECTOR_SPAN);
   localparam int HP_W   = HUE_W + $clog2(HUE_STEPS);
   localparam int MW     = HP_W - HUE_FRAC_BITS;
   localparam int DS     = MW + SPAN_L;
   localparam int QW     = (MW > SPAN_L) ? MW - SPAN_L + 1 : 1;
   localparam int QP_W   = DS + QW;
   localparam logic [QP_W-1:0] RECIP_SPAN =
      QP_W'(((64'd1 << DS) + 64'(SECTOR_SPAN - 1)) / 64'(SECTOR_SPAN));
   localparam int S6     = QW + $clog2(SECTOR_COUNT);
   localparam int SP_W   = S6 + QW;
   localparam logic [SP_W-1:0] RECIP_SIX =
      SP_W'(((64'd1 << S6) + 64'(SECTOR_COUNT - 1)) / 64'(SECTOR_COUNT));
   localparam int KX     = MW + K_W;
   localparam int SX     = QW + $clog2(SECTOR_COUNT);
   localparam int PP_W   = PROD_W + P_RECIP_W;

   // valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // stage 1
   logic [HP_W-1:0]   hp1_ff, hp1_in;
   logic [PROD_W-1:0] pp1_ff, pp1_in;
   logic [CHAN_W-1:0] sat1_ff, val1_ff;
   // stage 2
   logic [MW-1:0]     m_w;
   logic [MW-1:0]     m2_ff;
   logic [QP_W-1:0]   qm2_ff, qm2_in;
   logic [PP_W-1:0]   pdiv;
   logic [CHAN_W-1:0] p2_ff, p2_in;
   logic [CHAN_W-1:0] sat2_ff, val2_ff;
   // stage 3
   logic [QW-1:0]     quo_w;
   logic [KX-1:0]     kx;
   logic [QW-1:0]     quo3_ff;
   logic [K_W-1:0]    k3_ff, k3_in;
   logic [CHAN_W-1:0] sat3_ff, val3_ff, p3_ff;
   // stage 4
   logic [SP_W-1:0]   q6p4_ff, q6p4_in;
   logic [QW-1:0]     quo4_ff;
   logic [NUM_W-1:0]  nq4_ff, nq4_in, nt4_ff, nt4_in;
   logic [CHAN_W-1:0] val4_ff, p4_ff;
   // stage 5
   logic [QW-1:0]     q6_w;
   logic [SX-1:0]     secx;
   sector_type        sec5_ff, sec5_in;
   logic [CHAN_W-1:0] val5_ff, p5_ff;
   // stage 6
   sector_type        sec6_ff;
   logic [CHAN_W-1:0] val6_ff, p6_ff;
   logic [CHAN_W-1:0] q6_s, t6_s;
   // output
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;

   // no back-pressure anywhere in the pipe
   assign busy = 1'b0;

   // stage 1: hue in steps, numerator of the p term
   assign hp1_in = HP_W'(req_hue) * HP_W'(HUE_STEPS);
   assign pp1_in = PROD_W'(req_brightness) * PROD_W'(CHAN_MAX - req_saturation);

   // stage 2: m / 1000 by reciprocal, p = pp / 255
   assign m_w    = hp1_ff[HP_W-1 -: MW];
   assign qm2_in = QP_W'(m_w) * RECIP_SPAN;
   assign pdiv   = PP_W'(pp1_ff) * PP_W'(P_RECIP);
   assign p2_in  = pdiv[P_SHIFT +: CHAN_W];

   // stage 3: remainder within the sector
   assign quo_w = qm2_ff[DS +: QW];
   assign kx    = KX'(m2_ff) - KX'(quo_w) * KX'(SECTOR_SPAN);
   assign k3_in = kx[K_W-1:0];

   // stage 4: scaler factors and quotient by six
   assign q6p4_in = SP_W'(quo3_ff) * RECIP_SIX;
   assign nq4_in  = SCALE_FULL - NUM_W'(sat3_ff) * NUM_W'(k3_ff);
   assign nt4_in  = SCALE_FULL
                    - NUM_W'(sat3_ff) * NUM_W'(K_W'(SECTOR_SPAN) - k3_ff);

   // stage 5: sector = quotient mod 6
   assign q6_w    = q6p4_ff[S6 +: QW];
   assign secx    = SX'(quo4_ff) - SX'(q6_w) * SX'(SECTOR_COUNT);
   assign sec5_in = sector_type'(secx[2:0]);

   hsvrgb_scale u_scale_q (
      .clock  (clock),
      .value  (val4_ff),
      .factor (nq4_ff),
      .scaled (q6_s)
   );

   hsvrgb_scale u_scale_t (
      .clock  (clock),
      .value  (val4_ff),
      .factor (nt4_ff),
      .scaled (t6_s)
   );

   // stage 7: route terms to channels by sector
   always_comb begin
      red_in   = val6_ff;
      green_in = p6_ff;
      blue_in  = q6_s;
      case (sec6_ff)
         SEC_RED_YELLOW: begin
            red_in = val6_ff; green_in = t6_s;    blue_in = p6_ff;
         end
         SEC_YELLOW_GREEN: begin
            red_in = q6_s;    green_in = val6_ff; blue_in = p6_ff;
         end
         SEC_GREEN_CYAN: begin
            red_in = p6_ff;   green_in = val6_ff; blue_in = t6_s;
         end
         SEC_CYAN_BLUE: begin
            red_in = p6_ff;   green_in = q6_s;    blue_in = val6_ff;
         end
         SEC_BLUE_MAGENTA: begin
            red_in = t6_s;    green_in = p6_ff;   blue_in = val6_ff;
         end
         SEC_MAGENTA_RED: begin
            red_in = val6_ff; green_in = p6_ff;   blue_in = q6_s;
         end
         default: begin
            red_in = val6_ff; green_in = p6_ff;   blue_in = q6_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      hp1_ff   <= hp1_in;
      pp1_ff   <= pp1_in;
      sat1_ff  <= req_saturation;
      val1_ff  <= req_brightness;

      m2_ff    <= m_w;
      qm2_ff   <= qm2_in;
      p2_ff    <= p2_in;
      sat2_ff  <= sat1_ff;
      val2_ff  <= val1_ff;

      quo3_ff  <= quo_w;
      k3_ff    <= k3_in;
      sat3_ff  <= sat2_ff;
      val3_ff  <= val2_ff;
      p3_ff    <= p2_ff;

      q6p4_ff  <= q6p4_in;
      quo4_ff  <= quo3_ff;
      nq4_ff   <= nq4_in;
      nt4_ff   <= nt4_in;
      val4_ff  <= val3_ff;
      p4_ff    <= p3_ff;

      sec5_ff  <= sec5_in;
      val5_ff  <= val4_ff;
      p5_ff    <= p4_ff;

      sec6_ff  <= sec5_ff;
      val6_ff  <= val5_ff;
      p6_ff    <= p5_ff;

      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = v7_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

### sv/hsvrgb_check.sv
`timescale 1ns / 1ps
// Port-level checks of the HSV to RGB converter, bound to the top level.
module hsvrgb_check
   import hsvrgb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [HUE_W-1:0]   req_hue,
   input logic [CHAN_W-1:0]  req_saturation,
   input logic [CHAN_W-1:0]  req_brightness,
   input logic               rsp_valid,
   input logic [CHAN_W-1:0]  rsp_red,
   input logic [CHAN_W-1:0]  rsp_green,
   input logic [CHAN_W-1:0]  rsp_blue
);

   // every taken transaction yields its result a fixed time later
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result strobe missing after accepted transaction");

   // no result without a transaction behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without accepted transaction");

   // zero saturation gives grey at the requested brightness
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |-> ##LATENCY
         (rsp_red == $past(req_brightness, LATENCY)
          && rsp_green == $past(req_brightness, LATENCY)
          && rsp_blue == $past(req_brightness, LATENCY)))
      else $error("grey input not returned as grey");

   // no channel is brighter than the requested brightness
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= $past(req_brightness, LATENCY)
                     && rsp_green <= $past(req_brightness, LATENCY)
                     && rsp_blue <= $past(req_brightness, LATENCY)))
      else $error("channel exceeds brightness");

endmodule

bind hsv_to_rgb_fixed_hue hsvrgb_check u_hsvrgb_check (.*);
